// ===== sv/base64_stream_decoder_defines.svh =====
// ---------------------------------------------------------------------------
// Base64 stream decoder assertion macros
// Shared assertion shorthands for the decoder modules. Each macro expects
// signals named clk and rst_n in the module that uses it.
// ---------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define B64D_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("b64d: same-cycle check failed");
`define B64D_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("b64d: next-cycle check failed");
`else
`define B64D_ASSERT_IMP(lbl, ante, cons)
`define B64D_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== sv/b64d_pkg.sv =====
// ---------------------------------------------------------------------------
// Base64 decoder package
// Character codes, status codes, the command that links the front and back
// halves, and the character classification function.
// ---------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

    localparam logic [7:0] SX_BAD      = 8'hFF;
    localparam logic [7:0] SX_PAD      = 8'hFE;

    localparam logic [7:0] CH_EQUALS   = 8'h3D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0  = 8'h30;
    localparam logic [7:0] CH_DIGIT_9  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_LENGTH = 2'd1,
        ST_INVALID    = 2'd2
    } status_t;

    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  count;
        logic        last;
        status_t     status;
    } b64d_cmd_t;

    function automatic logic [7:0] char_value(input logic [7:0] c);
        logic [7:0] v;
        begin
            priority if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
                v = c - CH_UPPER_A;
            else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
                v = c - CH_LOWER_A + 8'd26;
            else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
                v = c - CH_DIGIT_0 + 8'd52;
            else if (c == CH_PLUS)
                v = 8'd62;
            else if (c == CH_SLASH)
                v = 8'd63;
            else if (c == CH_EQUALS)
                v = SX_PAD;
            else
                v = SX_BAD;
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/b64d_in_if.sv =====
// ---------------------------------------------------------------------------
// Base64 decoder character channel
// Valid/ready channel carrying one encoded character and its last flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

`default_nettype wire

// ===== sv/b64d_out_if.sv =====
// ---------------------------------------------------------------------------
// Base64 decoder result channel
// Valid/ready channel carrying one decoded byte with end mark and status.
// ---------------------------------------------------------------------------
`default_nettype none

interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       end_mark;
    logic [1:0] status;

    modport source (output valid, output out_byte, output has_byte,
                    output end_mark, output status, input ready);
    modport sink   (input valid, input out_byte, input has_byte,
                    input end_mark, input status, output ready);
endinterface

`default_nettype wire

// ===== sv/b64d_front.sv =====
// ---------------------------------------------------------------------------
// Base64 decoder front end
// Accepts characters, tracks quad phase, padding, trailing whitespace and
// errors, and issues one byte-group command per completed output decision.
// ---------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_decoder_defines.svh"

module b64d_front
    import b64d_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    b64d_in_if.sink    enc,
    output b64d_cmd_t  push_cmd,
    output logic       push,
    input  wire logic  full
);

    logic [17:0] accum_reg,      accum_next;
    logic [1:0]  phase_reg,      phase_next;
    logic        third_pad_reg,  third_pad_next;
    logic [23:0] held_quad_reg,  held_quad_next;
    logic        held_valid_reg, held_valid_next;
    logic [1:0]  held_pad_reg,   held_pad_next;
    logic [1:0]  ws_count_reg,   ws_count_next;
    logic        ws_seen_reg,    ws_seen_next;
    logic        invalid_reg,    invalid_next;

    logic       accept;
    logic       is_ws;
    logic [7:0] v;
    logic       is_pad;
    logic [5:0] s;
    logic [1:0] phase_eff;
    logic       emit3;
    status_t    st;

    assign enc.ready = !full;
    assign accept    = enc.valid && enc.ready;

    always_comb
    begin
        is_ws  = (enc.in_char == CH_LF) || (enc.in_char == CH_CR) ||
                 (enc.in_char == CH_SPACE);
        v      = char_value(enc.in_char);
        is_pad = (v == SX_PAD);
        s      = (v[7:6] != 2'd0) ? 6'd0 : v[5:0];

        accum_next      = accum_reg;
        phase_next      = phase_reg;
        third_pad_next  = third_pad_reg;
        held_quad_next  = held_quad_reg;
        held_valid_next = held_valid_reg;
        held_pad_next   = held_pad_reg;
        ws_count_next   = ws_count_reg;
        ws_seen_next    = ws_seen_reg;
        invalid_next    = invalid_reg;
        phase_eff       = phase_reg;
        emit3           = 1'b0;

        if (is_ws)
        begin
            ws_count_next = 2'(ws_count_reg + 2'd1);
            ws_seen_next  = 1'b1;
        end
        else
        begin
            // Pending whitespace followed by text counts as invalid characters.
            phase_eff     = ws_seen_reg ? 2'(phase_reg + ws_count_reg) : phase_reg;
            invalid_next  = invalid_reg || ws_seen_reg || (v == SX_BAD);
            ws_count_next = 2'd0;
            ws_seen_next  = 1'b0;
            emit3           = held_valid_reg && !invalid_next;
            held_valid_next = 1'b0;
            unique case (phase_eff)
                2'd0:
                begin
                    accum_next     = {12'd0, s};
                    third_pad_next = 1'b0;
                end
                2'd1:
                begin
                    accum_next = {accum_reg[11:0], s};
                end
                2'd2:
                begin
                    accum_next     = {accum_reg[11:0], s};
                    third_pad_next = is_pad;
                end
                2'd3:
                begin
                    held_quad_next  = {accum_reg, s};
                    held_pad_next   = is_pad ? (third_pad_reg ? 2'd2 : 2'd1) : 2'd0;
                    held_valid_next = 1'b1;
                end
            endcase
            phase_next = 2'(phase_eff + 2'd1);
        end

        if (phase_next != 2'd0)
            st = ST_BAD_LENGTH;
        else if (invalid_next)
            st = ST_INVALID;
        else
            st = ST_OK;

        push_cmd.bytes  = held_quad_reg;
        push_cmd.count  = 2'd3;
        push_cmd.last   = enc.in_last;
        push_cmd.status = ST_OK;
        if (enc.in_last)
        begin
            // The final step delivers at most one quad's worth of bytes.
            priority if (st != ST_OK)
            begin
                push_cmd.count  = 2'd0;
                push_cmd.status = st;
            end
            else if (emit3)
            begin
                push_cmd.count = 2'd3;
            end
            else if (held_valid_next)
            begin
                push_cmd.bytes = held_quad_next;
                push_cmd.count = 2'(2'd3 - held_pad_next);
            end
            else
            begin
                push_cmd.count = 2'd0;
            end
        end
        push = accept && (enc.in_last || emit3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg      <= '0;
            phase_reg      <= '0;
            third_pad_reg  <= 1'b0;
            held_quad_reg  <= '0;
            held_valid_reg <= 1'b0;
            held_pad_reg   <= '0;
            ws_count_reg   <= '0;
            ws_seen_reg    <= 1'b0;
            invalid_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (enc.in_last)
            begin
                accum_reg      <= '0;
                phase_reg      <= '0;
                third_pad_reg  <= 1'b0;
                held_quad_reg  <= '0;
                held_valid_reg <= 1'b0;
                held_pad_reg   <= '0;
                ws_count_reg   <= '0;
                ws_seen_reg    <= 1'b0;
                invalid_reg    <= 1'b0;
            end
            else
            begin
                accum_reg      <= accum_next;
                phase_reg      <= phase_next;
                third_pad_reg  <= third_pad_next;
                held_quad_reg  <= held_quad_next;
                held_valid_reg <= held_valid_next;
                held_pad_reg   <= held_pad_next;
                ws_count_reg   <= ws_count_next;
                ws_seen_reg    <= ws_seen_next;
                invalid_reg    <= invalid_next;
            end
        end
    end

    `B64D_ASSERT_NXT(a_last_clears_stream, accept && enc.in_last,
        phase_reg == 2'd0 && !held_valid_reg && !invalid_reg && !ws_seen_reg)
    `B64D_ASSERT_IMP(a_error_sends_no_bytes, push && push_cmd.status != ST_OK,
        push_cmd.count == 2'd0 && push_cmd.last)

endmodule

`default_nettype wire

// ===== sv/b64d_queue.sv =====
// ---------------------------------------------------------------------------
// Base64 decoder command queue
// Short first-in first-out queue of byte-group commands between the front
// end and the beat sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_decoder_defines.svh"

module b64d_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire b64d_cmd_t  push_cmd,
    output logic            full,
    input  wire logic       pop,
    output b64d_cmd_t       pop_cmd,
    output logic            empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_cmd_t       slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg,  count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        if (push && !pop)
            count_next = CW'(count_reg + 1'b1);
        else if (pop && !push)
            count_next = CW'(count_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `B64D_ASSERT_IMP(a_no_push_when_full, push, !full)
    `B64D_ASSERT_IMP(a_no_pop_when_empty, pop, !empty)

endmodule

`default_nettype wire

// ===== sv/b64d_back.sv =====
// ---------------------------------------------------------------------------
// Base64 decoder beat sequencer
// Takes byte-group commands from the queue and sends them out one byte per
// beat from a registered command, placing end mark and status on the last.
// ---------------------------------------------------------------------------
`default_nettype none
`include "base64_stream_decoder_defines.svh"

module b64d_back
    import b64d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    b64d_out_if.source      dec,
    output logic            pop,
    input  wire b64d_cmd_t  pop_cmd,
    input  wire logic       empty
);

    b64d_cmd_t   cur_reg;
    logic        cur_valid_reg, cur_valid_next;
    logic [1:0]  idx_reg,       idx_next;
    logic        final_beat;
    logic        no_bytes;
    logic [7:0]  sel_byte;

    assign no_bytes   = (cur_reg.count == 2'd0);
    assign final_beat = no_bytes || (idx_reg == 2'(cur_reg.count - 2'd1));

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel_byte = cur_reg.bytes[23:16];
            2'd1:    sel_byte = cur_reg.bytes[15:8];
            default: sel_byte = cur_reg.bytes[7:0];
        endcase
    end

    assign dec.valid    = cur_valid_reg;
    assign dec.out_byte = no_bytes ? 8'd0 : sel_byte;
    assign dec.has_byte = !no_bytes;
    assign dec.end_mark = cur_reg.last && final_beat;
    assign dec.status   = no_bytes ? cur_reg.status : ST_OK;

    assign pop = !empty && (!cur_valid_reg || (dec.ready && final_beat));

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (cur_valid_reg && dec.ready)
        begin
            if (final_beat)
                cur_valid_next = 1'b0;
            else
                idx_next = 2'(idx_reg + 2'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= pop_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    `B64D_ASSERT_IMP(a_empty_beat_is_end, dec.valid && !dec.has_byte, dec.end_mark)

endmodule

`default_nettype wire

// ===== sv/base64_stream_decoder.sv =====
// ---------------------------------------------------------------------------
// Base64 stream decoder
// Decodes standard base64 text, one character per beat on enc, into bytes
// on dec, with an end mark and a status on the final beat of each stream.
//
// enc carries in_char and in_last; dec carries out_byte, has_byte, end_mark
// and status (0 ok, 1 bad length, 2 invalid character).
// The front end takes one character per cycle whenever the command queue
// has room. A completed quad is held until the next non-whitespace
// character arrives; its bytes then pass through the command queue into
// the registered command of the beat sequencer and go out at one beat per
// cycle while dec is ready. On the final character the last bytes, or a
// single end beat without a byte, take the same path. Four characters give
// at most three beats, so while dec is ready the block sustains one character
// per cycle; the queue absorbs the three-beat burst of a released quad.
// When dec is stalled, commands gather in the QUEUE_DEPTH-entry queue and
// enc.ready falls once it is full. Reset clears all stream state, the
// queue and the output stage; no beat is pending after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    b64d_in_if.sink    enc,
    b64d_out_if.source dec
);

    b64d_cmd_t push_cmd;
    b64d_cmd_t pop_cmd;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;

    b64d_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .enc      (enc),
        .push_cmd (push_cmd),
        .push     (push),
        .full     (full)
    );

    b64d_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    b64d_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .dec     (dec),
        .pop     (pop),
        .pop_cmd (pop_cmd),
        .empty   (empty)
    );

endmodule

`default_nettype wire

// ===== verif/base64_stream_decoder_test.sv =====
// ---------------------------------------------------------------------------
// Base64 stream decoder testbench
// Feeds encoded characters to the decoder and checks every result beat
// against a behavioural decoder, or against the table for typed rows. A short
// hand-written table comes first; random well-formed and broken streams follow,
// under three idling mixes.
module base64_stream_decoder_test;
    import b64d_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_mark;
        status_t    status;
    } beat_t;

    typedef struct packed {
        logic [7:0]      ch;
        logic            last;
        logic            typed;
        logic [1:0]      n_typed;
        beat_t [2:0]     beats;
    } row_t;

    localparam beat_t NO_BEAT = '0;

    logic clk;
    logic rst_n;

    b64d_in_if  enc ();
    b64d_out_if dec ();

    base64_stream_decoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .enc   (enc),
        .dec   (dec)
    );

    int    enc_idle_pct;
    int    dec_idle_pct;
    int    fail_count;
    beat_t awaited_beats [$];
    beat_t step_beats [$];
    row_t  stream_rows [$];

    logic [17:0] sextets;
    logic [1:0]  quad_pos;
    logic        third_pad;
    logic [23:0] held_word;
    logic        held_full;
    logic [1:0]  held_drop;
    logic [1:0]  ws_count;
    logic        ws_pending;
    logic        bad_char;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge clk)
    begin
        dec.ready <= ($urandom_range(99) >= dec_idle_pct);
    end

    function automatic logic [7:0] sextet_of(logic [7:0] c);
        if (c == CH_PLUS)
            return 8'd62;
        if (c == CH_SLASH)
            return 8'd63;
        if (c == CH_EQUALS)
            return SX_PAD;
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
            return c + 8'd4;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            return c - CH_UPPER_A;
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            return c - 8'd71;
        return SX_BAD;
    endfunction

    function automatic logic [7:0] b64_char(logic [5:0] v);
        if (v < 6'd26)
            return CH_UPPER_A + v;
        if (v < 6'd52)
            return CH_LOWER_A + (v - 6'd26);
        if (v < 6'd62)
            return CH_DIGIT_0 + (v - 6'd52);
        return (v == 6'd62) ? CH_PLUS : CH_SLASH;
    endfunction

    function automatic logic [7:0] ws_char();
        case ($urandom_range(2))
            0: return CH_LF;
            1: return CH_CR;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic beat_t byte_beat(logic [7:0] b, logic endm);
        return '{out_byte: b, has_byte: 1'b1, end_mark: endm, status: ST_OK};
    endfunction

    function automatic beat_t end_beat(status_t st);
        return '{out_byte: 8'd0, has_byte: 1'b0, end_mark: 1'b1, status: st};
    endfunction

    function automatic row_t plain_row(logic [7:0] ch, logic last);
        row_t r;
        r = '0;
        r.ch = ch;
        r.last = last;
        return r;
    endfunction

    function automatic row_t typed_row(logic [7:0] ch, logic last, logic [1:0] n,
                                       beat_t b0, beat_t b1, beat_t b2);
        row_t r;
        r = plain_row(ch, last);
        r.typed = 1'b1;
        r.n_typed = n;
        r.beats[0] = b0;
        r.beats[1] = b1;
        r.beats[2] = b2;
        return r;
    endfunction

    task automatic clear_decoder();
        sextets = '0;
        quad_pos = '0;
        third_pad = 1'b0;
        held_word = '0;
        held_full = 1'b0;
        held_drop = '0;
        ws_count = '0;
        ws_pending = 1'b0;
        bad_char = 1'b0;
    endtask

    task automatic decode_char(logic [7:0] ch, logic last);
        logic [7:0] v;
        logic [5:0] s;
        logic [7:0] outb [6];
        int         n;
        int         keep;
        int         k;
        status_t    st;
        step_beats.delete();
        n = 0;
        if (ch == CH_LF || ch == CH_CR || ch == CH_SPACE)
        begin
            ws_count = ws_count + 2'd1;
            ws_pending = 1'b1;
        end
        else
        begin
            if (ws_pending)
            begin
                bad_char = 1'b1;
                quad_pos = quad_pos + ws_count;
                ws_count = '0;
                ws_pending = 1'b0;
            end
            v = sextet_of(ch);
            if (v == SX_BAD)
                bad_char = 1'b1;
            if (held_full)
            begin
                if (!bad_char)
                begin
                    outb[0] = held_word[23:16];
                    outb[1] = held_word[15:8];
                    outb[2] = held_word[7:0];
                    n = 3;
                end
                held_full = 1'b0;
            end
            s = (v < 8'd64) ? v[5:0] : 6'd0;
            case (quad_pos)
                2'd0:
                begin
                    sextets = {12'd0, s};
                    third_pad = 1'b0;
                end
                2'd1: sextets = {sextets[11:0], s};
                2'd2:
                begin
                    sextets = {sextets[11:0], s};
                    third_pad = (v == SX_PAD);
                end
                default:
                begin
                    held_word = {sextets, s};
                    held_drop = (v == SX_PAD) ? (third_pad ? 2'd2 : 2'd1) : 2'd0;
                    held_full = 1'b1;
                end
            endcase
            quad_pos = quad_pos + 2'd1;
        end
        if (!last)
        begin
            for (k = 0; k < n; k++)
                step_beats = {step_beats, byte_beat(outb[k], 1'b0)};
        end
        else
        begin
            st = (quad_pos != 2'd0) ? ST_BAD_LENGTH : (bad_char ? ST_INVALID : ST_OK);
            if (st != ST_OK)
                n = 0;
            else if (held_full)
            begin
                keep = 3 - held_drop;
                outb[n++] = held_word[23:16];
                if (keep >= 2)
                    outb[n++] = held_word[15:8];
                if (keep >= 3)
                    outb[n++] = held_word[7:0];
            end
            if (n > 3)
                n = 3;
            if (n == 0)
                step_beats = {step_beats, end_beat(st)};
            else
                for (k = 0; k < n; k++)
                    step_beats = {step_beats, byte_beat(outb[k], k == n - 1)};
            clear_decoder();
        end
    endtask

    task automatic send_char(logic [7:0] ch, logic last);
        @(negedge clk);
        while ($urandom_range(99) < enc_idle_pct)
        begin
            enc.valid <= 1'b0;
            @(negedge clk);
        end
        enc.valid <= 1'b1;
        enc.in_char <= ch;
        enc.in_last <= last;
        do
            @(posedge clk);
        while (!enc.ready);
    endtask

    task automatic feed(row_t r);
        int k;
        send_char(r.ch, r.last);
        decode_char(r.ch, r.last);
        if (r.typed)
        begin
            for (k = 0; k < r.n_typed; k++)
                awaited_beats = {awaited_beats, r.beats[k]};
        end
        else
        begin
            for (k = 0; k < step_beats.size(); k++)
                awaited_beats = {awaited_beats, step_beats[k]};
        end
    endtask

    task automatic make_stream();
        logic [7:0] text [$];
        logic [7:0] noise;
        int         quads;
        int         pad;
        int         pick;
        int         pos;
        int         k;
        quads = $urandom_range(0, 4);
        for (k = 0; k < 4 * quads; k++)
            text = {text, b64_char(6'($urandom_range(0, 63)))};
        pad = (quads > 0) ? $urandom_range(0, 2) : 0;
        for (k = 1; k <= pad; k++)
            text[text.size() - k] = CH_EQUALS;
        pick = $urandom_range(0, 99);
        if (pick >= 70)
        begin
            pos = $urandom_range(0, text.size());
            noise = 8'($urandom_range(0, 255));
            case (pick % 5)
                0: if (text.size() != 0) text[pos % text.size()] = noise;
                1: if (text.size() != 0) text.delete(pos % text.size());
                2: if (text.size() != 0) text[pos % text.size()] = ws_char();
                3: text.insert(pos, CH_EQUALS);
                default:
                begin
                    repeat ($urandom_range(1, 8))
                    begin
                        noise = 8'($urandom_range(0, 255));
                        text = {text, noise};
                    end
                end
            endcase
        end
        repeat ($urandom_range(0, 3))
            text = {text, ws_char()};
        if (text.size() == 0)
            text = {text, ws_char()};
        stream_rows.delete();
        for (k = 0; k < text.size(); k++)
            stream_rows = {stream_rows, plain_row(text[k], k == text.size() - 1)};
    endtask

    task automatic run_random(int src_idle, int dst_idle, int count);
        int sent;
        int k;
        enc_idle_pct = src_idle;
        dec_idle_pct = dst_idle;
        sent = 0;
        while (sent < count)
        begin
            make_stream();
            for (k = 0; k < stream_rows.size(); k++)
                feed(stream_rows[k]);
            sent += stream_rows.size();
        end
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && dec.valid && dec.ready)
        begin
            if (awaited_beats.size() == 0)
            begin
                $error("out_byte: expected no beat, got %0h", dec.out_byte);
                fail_count++;
            end
            else
            begin
                want = awaited_beats.pop_front();
                check_field("out_byte", want.out_byte, dec.out_byte);
                check_field("has_byte", {7'd0, want.has_byte}, {7'd0, dec.has_byte});
                check_field("end_mark", {7'd0, want.end_mark}, {7'd0, dec.end_mark});
                check_field("status", {6'd0, want.status}, {6'd0, dec.status});
            end
        end
    end

    initial
    begin
        row_t plan [$];
        rst_n = 1'b0;
        enc.valid = 1'b0;
        enc.in_char = 8'd0;
        enc.in_last = 1'b0;
        dec.ready = 1'b0;
        enc_idle_pct = 13;
        dec_idle_pct = 81;
        fail_count = 0;
        clear_decoder();
        plan = '{
            typed_row(CH_LF, 1'b1, 2'd1, end_beat(ST_OK), NO_BEAT, NO_BEAT),
            typed_row("A", 1'b1, 2'd1, end_beat(ST_BAD_LENGTH), NO_BEAT, NO_BEAT),
            plain_row(CH_SLASH, 1'b0),
            plain_row(CH_SLASH, 1'b0),
            plain_row(CH_SLASH, 1'b0),
            typed_row(CH_SLASH, 1'b1, 2'd3, byte_beat(8'hFF, 1'b0),
                      byte_beat(8'hFF, 1'b0), byte_beat(8'hFF, 1'b1)),
            plain_row("A", 1'b0),
            plain_row("A", 1'b0),
            plain_row(CH_EQUALS, 1'b0),
            typed_row(CH_EQUALS, 1'b1, 2'd1, byte_beat(8'h00, 1'b1), NO_BEAT, NO_BEAT),
            plain_row(CH_EQUALS, 1'b0),
            plain_row(CH_PLUS, 1'b0),
            plain_row(CH_EQUALS, 1'b0),
            plain_row("0", 1'b0),
            plain_row("Z", 1'b0),
            plain_row("z", 1'b0),
            plain_row("9", 1'b0),
            plain_row(CH_EQUALS, 1'b0),
            plain_row(CH_SPACE, 1'b0),
            plain_row(CH_LF, 1'b1),
            plain_row("A", 1'b0),
            plain_row(8'hFF, 1'b0),
            plain_row(8'h00, 1'b0),
            typed_row("A", 1'b1, 2'd1, end_beat(ST_INVALID), NO_BEAT, NO_BEAT),
            plain_row("A", 1'b0),
            plain_row("A", 1'b0),
            plain_row(CH_CR, 1'b0),
            typed_row("A", 1'b1, 2'd1, end_beat(ST_INVALID), NO_BEAT, NO_BEAT)
        };
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        foreach (plan[i])
            feed(plan[i]);
        run_random(13, 81, 100);
        run_random(81, 13, 100);
        run_random(0, 0, 100);
        @(negedge clk);
        enc.valid <= 1'b0;
        while (awaited_beats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
